@@ hdl/gqa_pkg.sv @@
package gqa_pkg;

  localparam int HEADS    = 8;
  localparam int GROUPS   = 2;
  localparam int VEC_DIM  = 16;
  localparam int SEQ_MAX  = 64;

  localparam int HEAD_W    = 3;
  localparam int GROUP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int POS_W     = $clog2(SEQ_MAX);
  localparam int DIM_W     = $clog2(VEC_DIM);
  localparam int LEN_W     = 7;
  localparam int HD_W      = 5;
  localparam int QADDR_W   = $clog2(HEADS * VEC_DIM);
  localparam int KVADDR_W  = $clog2(GROUPS * SEQ_MAX * VEC_DIM);

  // Datapath widths.
  localparam int ACC_W    = 40;
  localparam int MUL_A_W  = 37;
  localparam int MUL_B_W  = 18;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int SCORE_W  = 27;
  localparam int E_W      = 28;
  localparam int W_W      = 17;
  localparam int WSUM_W   = 23;
  localparam int DCNT_W   = 6;

  localparam logic [MUL_B_W-1:0] LOG2E_Q16 = 18'd94548;
  localparam logic [31:0]        EXP_STEP_Q32 = 32'd4283353945;

  typedef enum logic [1:0] {
    OP_WRITE_Q = 2'd0,
    OP_WRITE_K = 2'd1,
    OP_WRITE_V = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_LEN   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SCORE_SCALE = 2'd0,
    REG_GROUP_SIZE  = 2'd1,
    REG_ACTIVE_DIMS = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT_RD,
    S_DOT_MAC,
    S_SCALE,
    S_SCORE,
    S_EXP_RD,
    S_EXP_MUL,
    S_EXP_W,
    S_ACC_RD,
    S_ACC_MAC,
    S_DIV_SETUP,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef logic [W_W-1:0] exp_table_t [256];

  // 2^(-f/256) in Q1.16, built by repeated multiplication with rounding.
  function automatic exp_table_t build_exp_table();
    logic [95:0] acc;
    exp_table_t  tab;
    acc = 96'd1 << 32;
    for (int f = 0; f < 256; f++) begin
      tab[f] = W_W'((acc + 96'h8000) >> 16);
      acc = (acc * {64'd0, EXP_STEP_Q32} + 96'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ hdl/gqa_req_if.sv @@
interface gqa_req_if import gqa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [HEAD_W-1:0]       head;
  logic                    group;
  logic [5:0]              position;
  logic [3:0]              dim;
  logic signed [15:0]      element;
  logic [LEN_W-1:0]        seq_len;

  modport source (output valid, operation, head, group, position, dim, element, seq_len,
                  input ready);
  modport sink   (input valid, operation, head, group, position, dim, element, seq_len,
                  output ready);
endinterface

@@ hdl/gqa_rsp_if.sv @@
interface gqa_rsp_if import gqa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [2:0]              out_head;
  logic [3:0]              out_dim;
  logic signed [15:0]      out_value;
  logic                    last;

  modport source (output valid, status, out_head, out_dim, out_value, last, input ready);
  modport sink   (input valid, status, out_head, out_dim, out_value, last, output ready);
endinterface

@@ hdl/grouped_query_attention_decode.sv @@
// Single-token grouped-query attention. A store write (query, key or value element) gives
// no result unless an index is out of range. A compute item with a valid head and length
// keeps the block busy (req.ready low) while one shared multiplier is stepped through three
// passes: scores, then weights, then for each of the hd output elements a multiply-accumulate
// over the len positions, a set-up state, a restoring divider, a finishing state, and a
// state presenting the element until its transfer. The key and value stores are memories
// with registered read data, so each element is read in a state ahead of the one using it.
module grouped_query_attention_decode import gqa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gqa_req_if.sink      req,
  gqa_rsp_if.source    rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers.
  logic [15:0] score_scale;
  logic [3:0]  group_size;
  logic [4:0]  active_dims;
  reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      score_scale <= 16'd16384;
      group_size  <= 4'd4;
      active_dims <= 5'd16;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SCORE_SCALE: score_scale <= pwdata[15:0];
        REG_GROUP_SIZE:  group_size  <= pwdata[3:0];
        REG_ACTIVE_DIMS: active_dims <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCORE_SCALE: prdata = {16'd0, score_scale};
      REG_GROUP_SIZE:  prdata = {28'd0, group_size};
      REG_ACTIVE_DIMS: prdata = {27'd0, active_dims};
      default:         prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath registers.
  state_t state, state_next;

  logic [HEAD_W-1:0]       head_r;
  logic [GROUP_W-1:0]      g_r;
  logic [LEN_W-1:0]        len_r;
  logic [HD_W-1:0]         hd_r;
  logic [LEN_W-1:0]        n_cnt;
  logic [HD_W-1:0]         d_cnt;
  logic signed [ACC_W-1:0] acc;
  logic signed [SCORE_W-1:0] score_r;
  logic signed [SCORE_W-1:0] mx;
  logic [E_W-1:0]          e_r;
  logic [WSUM_W-1:0]       wsum;
  logic [ACC_W-1:0]        quo;
  logic [WSUM_W-1:0]       rem;
  logic                    neg;
  logic [DCNT_W-1:0]       div_cnt;

  logic [1:0]              out_status;
  logic [2:0]              out_head;
  logic [3:0]              out_dim;
  logic signed [15:0]      out_value;
  logic                    out_last;

  // Memories and their registered read data.
  logic signed [15:0]        query_mem  [HEADS*VEC_DIM];
  logic signed [15:0]        key_mem    [GROUPS*SEQ_MAX*VEC_DIM];
  logic signed [15:0]        value_mem  [GROUPS*SEQ_MAX*VEC_DIM];
  logic signed [SCORE_W-1:0] score_mem  [SEQ_MAX];
  logic [W_W-1:0]            weight_mem [SEQ_MAX];

  logic signed [15:0]        q_rd, k_rd, v_rd;
  logic signed [SCORE_W-1:0] s_rd;
  logic [W_W-1:0]            w_rd;

  logic req_fire, rsp_fire;
  op_t  req_op;
  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign req_op   = op_t'(req.operation);

  // Decode of the incoming item.
  logic [3:0]         hpg_eff;
  logic [HD_W-1:0]    hd_eff;
  logic [GROUP_W-1:0] g_calc;
  logic               wr_err, head_err, len_err;
  logic               wr_q, wr_k, wr_v;

  assign hpg_eff = (group_size == 4'd0) ? 4'd1 : group_size;

  always_comb begin
    if (active_dims == '0)
      hd_eff = HD_W'(1);
    else if (32'(active_dims) > VEC_DIM)
      hd_eff = HD_W'(VEC_DIM);
    else
      hd_eff = active_dims;
  end

  // The group is head / group_size, found by comparing against group boundaries.
  always_comb begin
    g_calc = '0;
    for (int k = 1; k < GROUPS; k++) begin
      if (32'(req.head) >= k * 32'(hpg_eff))
        g_calc = GROUP_W'(k);
    end
  end

  always_comb begin
    if (req_op == OP_WRITE_Q)
      wr_err = (32'(req.head) >= HEADS) || (32'(req.dim) >= VEC_DIM);
    else
      wr_err = (32'(req.group) >= GROUPS) || (32'(req.position) >= SEQ_MAX) ||
               (32'(req.dim) >= VEC_DIM);
  end

  assign head_err = (32'(req.head) >= HEADS) || (32'(req.head) >= GROUPS * 32'(hpg_eff));
  assign len_err  = (req.seq_len == '0) || (32'(req.seq_len) > SEQ_MAX);

  assign wr_q = req_fire && (req_op == OP_WRITE_Q) && !wr_err;
  assign wr_k = req_fire && (req_op == OP_WRITE_K) && !wr_err;
  assign wr_v = req_fire && (req_op == OP_WRITE_V) && !wr_err;

  logic [QADDR_W-1:0]  q_waddr, q_raddr;
  logic [KVADDR_W-1:0] kv_waddr, kv_raddr;
  logic [POS_W-1:0]    n_idx;

  assign q_waddr  = {req.head, req.dim};
  assign kv_waddr = {GROUP_W'(req.group), req.position, req.dim};
  assign n_idx    = n_cnt[POS_W-1:0];
  assign q_raddr  = {head_r, d_cnt[DIM_W-1:0]};
  assign kv_raddr = {g_r, n_idx, d_cnt[DIM_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_q)
      query_mem[q_waddr] <= req.element;
    q_rd <= query_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_k)
      key_mem[kv_waddr] <= req.element;
    k_rd <= key_mem[kv_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_v)
      value_mem[kv_waddr] <= req.element;
    v_rd <= value_mem[kv_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_SCORE)
      score_mem[n_idx] <= score_r;
    s_rd <= score_mem[n_idx];
  end

  logic [W_W-1:0] w_calc;
  logic [15:0]    ip;

  assign ip     = e_r[E_W-1:12];
  assign w_calc = (ip >= 16'd17) ? '0 : (EXP_TABLE[e_r[11:4]] >> ip[4:0]);

  always_ff @(posedge clk) begin
    if (state == S_EXP_W)
      weight_mem[n_idx] <= w_calc;
    w_rd <= weight_mem[n_idx];
  end

  // The one shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [SCORE_W:0]   diff;

  assign diff = (SCORE_W+1)'(mx) - (SCORE_W+1)'(s_rd);

  always_comb begin
    case (state)
      S_DOT_MAC: begin
        mul_a = MUL_A_W'(q_rd);
        mul_b = MUL_B_W'(k_rd);
      end
      S_SCALE: begin
        mul_a = acc[MUL_A_W-1:0];
        mul_b = {2'b00, score_scale};
      end
      S_EXP_MUL: begin
        mul_a = MUL_A_W'(diff);
        mul_b = LOG2E_Q16;
      end
      S_ACC_MAC: begin
        mul_a = {{(MUL_A_W-W_W){1'b0}}, w_rd};
        mul_b = MUL_B_W'(v_rd);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring division step.
  logic [WSUM_W:0] rem_sh;
  logic            rem_ge;
  assign rem_sh = {rem, quo[ACC_W-1]};
  assign rem_ge = rem_sh >= {1'b0, wsum};

  logic n_last, d_last;
  assign n_last = (n_cnt + LEN_W'(1)) == len_r;
  assign d_last = (d_cnt + HD_W'(1)) == hd_r;

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req_op != OP_COMPUTE)
            state_next = wr_err ? S_OUT : S_IDLE;
          else if (head_err || len_err)
            state_next = S_OUT;
          else
            state_next = S_DOT_RD;
        end
      end
      S_DOT_RD:    state_next = S_DOT_MAC;
      S_DOT_MAC:   state_next = d_last ? S_SCALE : S_DOT_RD;
      S_SCALE:     state_next = S_SCORE;
      S_SCORE:     state_next = n_last ? S_EXP_RD : S_DOT_RD;
      S_EXP_RD:    state_next = S_EXP_MUL;
      S_EXP_MUL:   state_next = S_EXP_W;
      S_EXP_W:     state_next = n_last ? S_ACC_RD : S_EXP_RD;
      S_ACC_RD:    state_next = S_ACC_MAC;
      S_ACC_MAC:   state_next = n_last ? S_DIV_SETUP : S_ACC_RD;
      S_DIV_SETUP: state_next = S_DIV;
      S_DIV:       state_next = (div_cnt == DCNT_W'(ACC_W - 1)) ? S_FIN : S_DIV;
      S_FIN:       state_next = S_OUT;
      S_OUT: begin
        if (rsp_fire)
          state_next = out_last ? S_IDLE : S_ACC_RD;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          head_r     <= req.head;
          g_r        <= g_calc;
          len_r      <= req.seq_len;
          hd_r       <= hd_eff;
          n_cnt      <= '0;
          d_cnt      <= '0;
          acc        <= '0;
          wsum       <= '0;
          out_head   <= req.head;
          out_dim    <= '0;
          out_value  <= '0;
          out_last   <= 1'b1;
          if (req_op != OP_COMPUTE || head_err)
            out_status <= ST_INDEX;
          else
            out_status <= ST_LEN;
        end
      end
      S_DOT_MAC: begin
        acc   <= acc + ACC_W'(mul_p);
        d_cnt <= d_cnt + HD_W'(1);
      end
      S_SCALE: score_r <= mul_p[MUL_P_W-1:28];
      S_SCORE: begin
        if (n_cnt == '0 || score_r > mx)
          mx <= score_r;
        acc   <= '0;
        d_cnt <= '0;
        n_cnt <= n_last ? '0 : n_cnt + LEN_W'(1);
      end
      S_EXP_MUL: e_r <= mul_p[E_W+15:16];
      S_EXP_W: begin
        wsum  <= wsum + WSUM_W'(w_calc);
        acc   <= '0;
        n_cnt <= n_last ? '0 : n_cnt + LEN_W'(1);
      end
      S_ACC_MAC: begin
        acc   <= acc + ACC_W'(mul_p);
        n_cnt <= n_last ? n_cnt : n_cnt + LEN_W'(1);
      end
      S_DIV_SETUP: begin
        neg     <= acc[ACC_W-1];
        quo     <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        rem     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        if (rem_ge)
          rem <= WSUM_W'(rem_sh - {1'b0, wsum});
        else
          rem <= rem_sh[WSUM_W-1:0];
        quo     <= {quo[ACC_W-2:0], rem_ge};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      S_FIN: begin
        out_status <= ST_OK;
        out_head   <= head_r;
        out_dim    <= d_cnt[DIM_W-1:0];
        out_last   <= d_last;
        if (wsum == '0)
          out_value <= '0;
        else if (neg)
          out_value <= (quo > ACC_W'(32768)) ? 16'sh8000 : -$signed(quo[15:0]);
        else
          out_value <= (quo > ACC_W'(32767)) ? 16'sh7FFF : $signed(quo[15:0]);
      end
      S_OUT: begin
        if (rsp_fire && !out_last) begin
          d_cnt <= d_cnt + HD_W'(1);
          n_cnt <= '0;
          acc   <= '0;
        end
      end
      default: ;
    endcase
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_OUT);
  assign rsp.status    = out_status;
  assign rsp.out_head  = out_head;
  assign rsp.out_dim   = out_dim;
  assign rsp.out_value = out_value;
  assign rsp.last      = out_last;

`ifndef SYNTHESIS
  a_busy_while_result : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("input taken while a result waits");

  a_error_is_last : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> rsp.last) else $error("error result not last");

  a_div_nonzero : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (wsum != '0)) else $error("division by a zero weight sum");

  a_dim_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC_MAC) |-> (d_cnt < hd_r)) else $error("dimension counter overran");

  a_last_returns_idle : assert property (@(posedge clk) disable iff (rst)
    (rsp_fire && rsp.last) |=> (state == S_IDLE)) else $error("no return to idle");
`endif

endmodule
